// ===== rtl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants for the segment display scanner: request and
// response payloads, operation codes and fixed field widths.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int FUNC_W    = 3;
    localparam int POS_W     = 8;
    localparam int CHAR_W    = 8;
    localparam int SEL_ROW_W = 4;
    localparam int SEL_COL_W = 6;
    // row * cols + col: up to 15 * 64 + 63
    localparam int PROD_W    = 11;

    localparam logic [FUNC_W-1:0] FUNC_SCAN    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET_DOT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLR_DOT = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_REFRESH = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  column;
        logic [CHAR_W-1:0] char_value;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [CHAR_W-1:0]    read_value;
        logic                 drive_active;
        logic [CHAR_W-1:0]    seg_data;
        logic                 dot_on;
        logic [SEL_ROW_W-1:0] sel_row;
        logic [SEL_COL_W-1:0] sel_col;
    } rsp_t;

endpackage

// ===== rtl/segment_display_scanner.sv =====
// ----------------------------------------------------------------------------
// segment_display_scanner
// Double-buffered multiplexed segment display controller with a data RAM,
// a scan framebuffer and a small sequencer around one shared position unit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req/req_valid/req_stall; every request gives exactly
//   one response on rsp/rsp_valid/rsp_stall. A request is taken when valid is
//   high and stall is low.
//   Ordinary requests (scan tick, write, read, dot set/clear) go through
//   accept, position compute, RAM access and response load. A refresh
//   copies one cell per cycle through the data RAM read port, and its
//   response is loaded after the copy pass ends. After reset a clearing
//   pass zeroes all RAMs, one cell per cycle; req_stall stays high until
//   it ends. Config (display_enable) is written by cfg_write/cfg_data;
//   the user must write it only while idle; the block does not enforce it.
//   The response register lets the next request be accepted while a
//   response still waits; a new response waits in the sequencer while
//   rsp_stall holds the previous one.
// ----------------------------------------------------------------------------
module segment_display_scanner
    import sds_pkg::*;
#(
    parameter int NUM_ROWS = 4,
    parameter int NUM_COLS = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic cfg_data,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CELLS  = NUM_ROWS * NUM_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_ADDR     = 7'b0000100,
        ST_EXEC     = 7'b0001000,
        ST_COPY     = 7'b0010000,
        ST_COPY_END = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   enable_reg;
    req_t                   req_reg;
    logic                   inside_reg, inside_next;
    logic [ADDR_W-1:0]      cell_reg, cell_next;
    logic [ADDR_W-1:0]      cnt_reg, cnt_next;
    logic [ADDR_W-1:0]      prev_reg;
    logic                   pend_reg;
    logic                   drive_reg, drive_next;
    logic [SEL_ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [SEL_COL_W-1:0]   scan_col_reg, scan_col_next;
    logic [SEL_ROW_W-1:0]   sel_row_reg, sel_row_next;
    logic [SEL_COL_W-1:0]   sel_col_reg, sel_col_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic [POS_W-1:0]       au_row, au_col;
    logic                   au_inside;
    logic [ADDR_W-1:0]      au_cell;

    logic                   chars_we, dots_we, frame_we;
    logic [ADDR_W-1:0]      chars_waddr, frame_waddr, data_raddr;
    logic [CHAR_W-1:0]      chars_wdata, chars_rdata;
    logic                   dots_wdata, dots_rdata, data_re;
    logic [CHAR_W:0]        frame_wdata, frame_rdata;
    logic                   frame_re;
    logic                   is_scan, is_clear, is_exec, is_copy;
    logic                   rsp_free;

    assign is_scan  = (req_reg.func == FUNC_SCAN);
    assign is_clear = (state_reg == ST_CLEAR);
    assign is_exec  = (state_reg == ST_EXEC);
    assign is_copy  = (state_reg == ST_COPY);
    assign rsp_free = !(rsp_valid_reg && rsp_stall);

    assign au_row = is_scan ? POS_W'(scan_row_reg) : req_reg.row;
    assign au_col = is_scan ? POS_W'(scan_col_reg) : req_reg.column;

    sds_addr_unit #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS),
        .ADDR_W   (ADDR_W)
    ) u_addr (
        .row      (au_row),
        .column   (au_col),
        .in_range (au_inside),
        .cell_idx (au_cell)
    );

    // data RAM: chars and dots
    assign chars_we    = is_clear || (is_exec && req_reg.func == FUNC_WRITE && inside_reg);
    assign chars_waddr = is_clear ? cnt_reg : cell_reg;
    assign chars_wdata = is_clear ? '0 : req_reg.char_value;
    assign dots_we     = is_clear || (is_exec && inside_reg &&
                         (req_reg.func == FUNC_SET_DOT || req_reg.func == FUNC_CLR_DOT));
    assign dots_wdata  = !is_clear && (req_reg.func == FUNC_SET_DOT);
    assign data_re     = is_copy || (is_exec && req_reg.func == FUNC_READ);
    assign data_raddr  = is_copy ? cnt_reg : cell_reg;

    sds_ram #(.DEPTH(CELLS), .ADDR_W(ADDR_W), .WIDTH(CHAR_W)) u_chars (
        .clk   (clk),
        .we    (chars_we),
        .waddr (chars_waddr),
        .wdata (chars_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (chars_rdata)
    );

    sds_ram #(.DEPTH(CELLS), .ADDR_W(ADDR_W), .WIDTH(1)) u_dots (
        .clk   (clk),
        .we    (dots_we),
        .waddr (chars_waddr),
        .wdata (dots_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (dots_rdata)
    );

    // framebuffer: {dot, char}
    assign frame_we    = is_clear || (is_copy && pend_reg) || (state_reg == ST_COPY_END);
    assign frame_waddr = is_clear ? cnt_reg : prev_reg;
    assign frame_wdata = is_clear ? '0 : {dots_rdata, chars_rdata};
    assign frame_re    = is_exec && is_scan;

    sds_ram #(.DEPTH(CELLS), .ADDR_W(ADDR_W), .WIDTH(CHAR_W + 1)) u_frame (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .re    (frame_re),
        .raddr (cell_reg),
        .rdata (frame_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        inside_next    = inside_reg;
        cell_next      = cell_reg;
        cnt_next       = cnt_reg;
        drive_next     = drive_reg;
        scan_row_next  = scan_row_reg;
        scan_col_next  = scan_col_reg;
        sel_row_next   = sel_row_reg;
        sel_col_next   = sel_col_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                inside_next = au_inside;
                cell_next   = au_cell;
                state_next  = ST_EXEC;
            end
            ST_EXEC:
            begin
                drive_next   = is_scan && enable_reg && inside_reg;
                sel_row_next = scan_row_reg;
                sel_col_next = scan_col_reg;
                cnt_next     = '0;
                state_next   = (req_reg.func == FUNC_REFRESH) ? ST_COPY : ST_DONE;
                if (is_scan && enable_reg && inside_reg)
                begin
                    if (scan_col_reg == SEL_COL_W'(NUM_COLS - 1))
                    begin
                        scan_col_next = '0;
                        scan_row_next = (scan_row_reg == SEL_ROW_W'(NUM_ROWS - 1)) ?
                                        '0 : scan_row_reg + 1'b1;
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + 1'b1;
                    end
                end
            end
            ST_COPY:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_COPY_END;
                end
            end
            ST_COPY_END:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next = '0;
                    unique case (req_reg.func)
                        FUNC_SCAN, FUNC_REFRESH: rsp_next.ok = 1'b1;
                        FUNC_WRITE, FUNC_SET_DOT, FUNC_CLR_DOT: rsp_next.ok = inside_reg;
                        FUNC_READ:
                        begin
                            rsp_next.ok         = inside_reg;
                            rsp_next.read_value = inside_reg ? chars_rdata : '0;
                        end
                        default: rsp_next.ok = 1'b0;
                    endcase
                    if (is_scan && drive_reg)
                    begin
                        rsp_next.drive_active = 1'b1;
                        rsp_next.seg_data     = frame_rdata[CHAR_W-1:0];
                        rsp_next.dot_on       = frame_rdata[CHAR_W];
                        rsp_next.sel_row      = sel_row_reg;
                        rsp_next.sel_col      = sel_col_reg;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            enable_reg    <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            drive_reg     <= 1'b0;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= is_copy;
            drive_reg     <= drive_next;
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        inside_reg  <= inside_next;
        cell_reg    <= cell_next;
        prev_reg    <= cnt_reg;
        sel_row_reg <= sel_row_next;
        sel_col_reg <= sel_col_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/sds_ram.sv =====
// ----------------------------------------------------------------------------
// sds_ram
// Simple dual-port RAM: one write port, one read port with registered data
// that holds while no read is issued.
// ----------------------------------------------------------------------------
module sds_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int WIDTH  = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sds_addr_unit.sv =====
// ----------------------------------------------------------------------------
// sds_addr_unit
// Shared position unit: range check and cell index (row * cols + col) for
// both request positions and the scan position.
// ----------------------------------------------------------------------------
module sds_addr_unit
    import sds_pkg::*;
#(
    parameter int NUM_ROWS = 4,
    parameter int NUM_COLS = 8,
    parameter int ADDR_W   = 5
) (
    input  logic [POS_W-1:0]  row,
    input  logic [POS_W-1:0]  column,
    output logic              in_range,
    output logic [ADDR_W-1:0] cell_idx
);

    logic [PROD_W-1:0] prod;

    assign in_range = (row < POS_W'(NUM_ROWS)) && (column < POS_W'(NUM_COLS));
    assign prod     = PROD_W'(row[SEL_ROW_W-1:0]) * PROD_W'(NUM_COLS)
                    + PROD_W'(column[SEL_COL_W-1:0]);
    assign cell_idx = prod[ADDR_W-1:0];

endmodule
